@@ sv/assert_macros.svh @@
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define CAD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define CAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cad_pkg.sv @@
package cad_pkg;

    localparam int DEPTH_DEF      = 128;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK       = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

@@ sv/cad_if.sv @@
interface cad_req_if;
    import cad_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cad_rsp_if;
    import cad_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, output status, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

interface cad_cfg_if;
    import cad_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/cad_ram.sv @@
module cad_ram #(
    parameter int DEPTH      = cad_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cad_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [DATA_WIDTH-1:0]        i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr_b,
    output logic [DATA_WIDTH-1:0]        o_rdata_a,
    output logic [DATA_WIDTH-1:0]        o_rdata_b
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata_a;
    logic [DATA_WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ sv/circular_array_deque.sv @@
// Each request runs in order through the write, read, load sequence on the single entry
// memory (write at accept, read both ends, register the response); a new request is taken
// only once the last one is loaded, and the load waits while a held response is not taken.
// A stalled response sits in the output register while the next request is accepted.
// Reset (synchronous, active low): deque empty, both indices zero, capacity DEPTH;
// the entry memory is not cleared.
module circular_array_deque #(
    parameter int DEPTH      = cad_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cad_pkg::DATA_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cad_req_if.sink        i_req,
    cad_cfg_if.sink        i_cfg,
    cad_rsp_if.source      o_rsp
);
    import cad_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] idx,
                                            input logic [AW-1:0] last);
        return (idx == last) ? '0 : idx + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] idx,
                                            input logic [AW-1:0] last);
        return (idx == '0) ? last : idx - AW'(1);
    endfunction

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_front, n_front;
    logic [AW-1:0]            r_rear, n_rear;
    logic                     r_empty, n_empty;
    logic [AW-1:0]            r_last;
    t_status                  r_status, n_status;

    logic                     r_out_valid;
    t_status                  r_out_status;
    logic signed [WORD_W-1:0] r_out_front;
    logic signed [WORD_W-1:0] r_out_rear;
    logic                     r_out_empty;
    logic                     r_out_full;

    logic                     w_accept;
    logic                     w_cfg;
    logic                     w_load;
    logic                     w_re;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [DATA_WIDTH-1:0]    w_wdata;
    logic [DATA_WIDTH-1:0]    w_rd_front;
    logic [DATA_WIDTH-1:0]    w_rd_rear;
    logic                     w_full;
    logic [EW-1:0]            w_cap_ext;
    logic [AW-1:0]            w_cfg_last;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_cfg    = i_cfg.valid && i_cfg.ready;
    assign w_full   = !r_empty && (f_inc(r_rear, r_last) == r_front);
    assign w_wdata  = DATA_WIDTH'($unsigned(i_req.value));

    assign i_cfg.ready = 1'b1;

    // clamp capacity to 1..DEPTH and keep the last usable index
    assign w_cap_ext = EW'(i_cfg.data);
    always_comb begin
        if (w_cap_ext == '0) begin
            w_cfg_last = '0;
        end else if (w_cap_ext > EW'(DEPTH)) begin
            w_cfg_last = AW'(DEPTH - 1);
        end else begin
            w_cfg_last = AW'(w_cap_ext - EW'(1));
        end
    end

    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_empty  = r_empty;
        n_status = STATUS_OK;
        w_we     = 1'b0;
        w_waddr  = '0;
        if (i_req.cmd inside {CMD_PUSH_FRONT, CMD_PUSH_REAR}) begin
            if (w_full) begin
                n_status = STATUS_OVERFLOW;
            end else if (r_empty) begin
                n_front = '0;
                n_rear  = '0;
                n_empty = 1'b0;
                w_we    = w_accept;
            end else if (i_req.cmd == CMD_PUSH_FRONT) begin
                n_front = f_dec(r_front, r_last);
                w_waddr = n_front;
                w_we    = w_accept;
            end else begin
                n_rear  = f_inc(r_rear, r_last);
                w_waddr = n_rear;
                w_we    = w_accept;
            end
        end else if (i_req.cmd inside {CMD_POP_FRONT, CMD_POP_REAR}) begin
            if (r_empty) begin
                n_status = STATUS_UNDERFLOW;
            end else if (r_front == r_rear) begin
                n_front = '0;
                n_rear  = '0;
                n_empty = 1'b1;
            end else if (i_req.cmd == CMD_POP_FRONT) begin
                n_front = f_inc(r_front, r_last);
            end else begin
                n_rear = f_dec(r_rear, r_last);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        w_re        = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                w_re    = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
            r_last  <= AW'(DEPTH - 1);
        end else if (w_cfg) begin
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
            r_last  <= w_cfg_last;
        end else if (w_accept) begin
            r_front <= n_front;
            r_rear  <= n_rear;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_status;
            r_out_front  <= r_empty ? '1 : WORD_W'($signed(w_rd_front));
            r_out_rear   <= r_empty ? '1 : WORD_W'($signed(w_rd_rear));
            r_out_empty  <= r_empty;
            r_out_full   <= w_full;
        end
    end

    // write lands at accept, reads follow in the next cycle: no same-entry overlap
    cad_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (r_front),
        .i_raddr_b (r_rear),
        .o_rdata_a (w_rd_front),
        .o_rdata_b (w_rd_rear)
    );

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.front_value = r_out_front;
    assign o_rsp.rear_value  = r_out_rear;
    assign o_rsp.is_empty    = r_out_empty;
    assign o_rsp.is_full     = r_out_full;

    `CAD_ASSERT_IMPL(a_idx_range, 1'b1, r_front <= r_last && r_rear <= r_last, "index beyond capacity")
    `CAD_ASSERT_IMPL(a_empty_idx, r_empty, r_front == '0 && r_rear == '0, "empty deque with index set")
    `CAD_ASSERT_NEXT(a_accept_read, w_accept, r_state == ST_READ, "accepted request not read")
    `CAD_ASSERT_NEXT(a_done_load, r_state == ST_DONE && !r_out_valid, r_out_valid, "response not loaded")

endmodule
